// ===== hdl/pira_pkg.sv =====
// pira_pkg: shared types and constants of the pi regulator with anti-windup
// no dependencies; used by every file of the block
package pira_pkg;

  localparam int unsigned DATA_W        = 16;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned FRAC_BITS     = 15;
  localparam int unsigned PROP_SHIFT    = 6;
  localparam int unsigned PROP_SAT_BITS = 31 - PROP_SHIFT;
  localparam int unsigned INTEG_W       = 32;
  localparam int unsigned EXCESS_W      = 18;
  localparam int unsigned BC_W          = EXCESS_W + DATA_W;
  localparam int unsigned ACC_W         = BC_W + 2;
  localparam int unsigned SUM_W         = INTEG_W + 1;
  localparam int unsigned RAW_W         = SUM_W - FRAC_BITS;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic signed [DATA_W-1:0] RST_INTEG_LOWER = -16'sd32768;
  localparam logic signed [DATA_W-1:0] RST_INTEG_UPPER = 16'sd32767;
  localparam logic signed [DATA_W-1:0] RST_DRIVE_LOWER = -16'sd32768;
  localparam logic signed [DATA_W-1:0] RST_DRIVE_UPPER = 16'sd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_INTEGRAL     = 3'd0,
    CFG_GAIN_PROPORTIONAL = 3'd1,
    CFG_GAIN_BACKCALC     = 3'd2,
    CFG_INTEG_LOWER       = 3'd3,
    CFG_INTEG_UPPER       = 3'd4,
    CFG_DRIVE_LOWER       = 3'd5,
    CFG_DRIVE_UPPER       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_integral;
    logic signed [DATA_W-1:0] gain_proportional;
    logic signed [DATA_W-1:0] gain_backcalc;
    logic signed [DATA_W-1:0] integ_lower;
    logic signed [DATA_W-1:0] integ_upper;
    logic signed [DATA_W-1:0] drive_lower;
    logic signed [DATA_W-1:0] drive_upper;
  } cfg_t;

  // products of one error sample, held in the input stage
  typedef struct packed {
    logic signed [PROD_W-1:0]        integ_inc;
    logic signed [PROP_SAT_BITS-1:0] prop;
  } prod_t;

endpackage

// ===== hdl/pira_if.sv =====
// pira_err_if / pira_drive_if: valid/ready channels of the pi regulator
// depends on pira_pkg for the field widths
interface pira_err_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pira_pkg::DATA_W-1:0]   error;

  modport source (output valid, output error, input ready);
  modport sink   (input valid, input error, output ready);
endinterface

interface pira_drive_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pira_pkg::DATA_W-1:0]   drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== hdl/pi_regulator_anti_windup.sv =====
// pi_regulator_anti_windup: top level of the pi regulator with back-calculation
// depends on pira_pkg, pira_if, pira_cfg, pira_gain, pira_core
//
// PI regulator with a Q15 integrator and back-calculation anti-windup: one
// signed error item in, one clamped drive item out. The block takes one item
// per clock cycle unless output back-pressure holds it; each item passes the
// input stage, which registers error*gain_integral and the saturated
// error*gain_proportional, then the result stage, which closes the state loop
// ahead of its drive register (excess*gain_backcalc multiply, integrator add
// and clamp, proportional add, shift, output clamp, new excess). Either stage
// holds while the next one is full, so a result waiting at the output does
// not stop the next item from entering. Configuration registers are written
// with cfg_we, cfg_index and cfg_wdata; the user must do so only while no
// item is in flight, which the block does not enforce. Index 7 is ignored.
module pi_regulator_anti_windup (
  input  logic                               clk,
  input  logic                               rst_n,
  pira_err_if.sink                           in_chan,
  pira_drive_if.source                       out_chan,
  input  logic                               cfg_we,
  input  logic [pira_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pira_pkg::DATA_W-1:0]        cfg_wdata
);

  pira_pkg::cfg_t   cfg;
  pira_pkg::prod_t  s1_prod;
  logic             s1_valid;
  logic             s1_take;

  pira_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pira_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_prod  (s1_prod)
  );

  pira_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_prod  (s1_prod),
    .s1_take  (s1_take),
    .out_chan (out_chan)
  );

endmodule

// ===== hdl/pira_cfg.sv =====
// pira_cfg: configuration register bank written through the plain write port
// depends on pira_pkg
module pira_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pira_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pira_pkg::DATA_W-1:0]            cfg_wdata,
  output pira_pkg::cfg_t                         cfg
);

  pira_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pira_pkg::cfg_idx_t'(cfg_index))
        pira_pkg::CFG_GAIN_INTEGRAL:     cfg_nxt.gain_integral     = $signed(cfg_wdata);
        pira_pkg::CFG_GAIN_PROPORTIONAL: cfg_nxt.gain_proportional = $signed(cfg_wdata);
        pira_pkg::CFG_GAIN_BACKCALC:     cfg_nxt.gain_backcalc     = $signed(cfg_wdata);
        pira_pkg::CFG_INTEG_LOWER:       cfg_nxt.integ_lower       = $signed(cfg_wdata);
        pira_pkg::CFG_INTEG_UPPER:       cfg_nxt.integ_upper       = $signed(cfg_wdata);
        pira_pkg::CFG_DRIVE_LOWER:       cfg_nxt.drive_lower       = $signed(cfg_wdata);
        pira_pkg::CFG_DRIVE_UPPER:       cfg_nxt.drive_upper       = $signed(cfg_wdata);
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_integral     <= '0;
      cfg_r.gain_proportional <= '0;
      cfg_r.gain_backcalc     <= '0;
      cfg_r.integ_lower       <= pira_pkg::RST_INTEG_LOWER;
      cfg_r.integ_upper       <= pira_pkg::RST_INTEG_UPPER;
      cfg_r.drive_lower       <= pira_pkg::RST_DRIVE_LOWER;
      cfg_r.drive_upper       <= pira_pkg::RST_DRIVE_UPPER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/pira_gain.sv =====
// pira_gain: input stage, multiplies the error by the integral and
// proportional gains and saturates the proportional term; depends on pira_pkg, pira_if
module pira_gain (
  input  logic              clk,
  input  logic              rst_n,
  pira_err_if.sink          in_chan,
  input  pira_pkg::cfg_t    cfg,
  input  logic              s1_take,
  output logic              s1_valid,
  output pira_pkg::prod_t   s1_prod
);

  localparam int unsigned PW = pira_pkg::PROP_SAT_BITS;

  logic                                 s1_valid_r, s1_valid_nxt;
  pira_pkg::prod_t                      s1_prod_r;
  logic                                 accept;
  logic signed [pira_pkg::PROD_W-1:0]   integ_inc;
  logic signed [pira_pkg::PROD_W-1:0]   prop_full;
  logic [pira_pkg::PROD_W-PW:0]         prop_top;
  logic signed [PW-1:0]                 prop_sat;

  assign in_chan.ready = !s1_valid_r || s1_take;
  assign accept        = in_chan.valid && in_chan.ready;

  assign integ_inc = in_chan.error * cfg.gain_integral;
  assign prop_full = in_chan.error * cfg.gain_proportional;
  assign prop_top  = prop_full[pira_pkg::PROD_W-1:PW-1];

  // fits when all bits above the sign of the narrow form agree
  always_comb begin
    if ((&prop_top) || !(|prop_top)) begin
      prop_sat = prop_full[PW-1:0];
    end else if (prop_full[pira_pkg::PROD_W-1]) begin
      prop_sat = {1'b1, {(PW-1){1'b0}}};
    end else begin
      prop_sat = {1'b0, {(PW-1){1'b1}}};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r.integ_inc <= integ_inc;
      s1_prod_r.prop      <= prop_sat;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_prod  = s1_prod_r;

endmodule

// ===== hdl/pira_core.sv =====
// pira_core: result stage, integrator and excess state, back-calculation,
// clamps and the drive register; depends on pira_pkg, pira_if
module pira_core (
  input  logic              clk,
  input  logic              rst_n,
  input  pira_pkg::cfg_t    cfg,
  input  logic              s1_valid,
  input  pira_pkg::prod_t   s1_prod,
  output logic              s1_take,
  pira_drive_if.source      out_chan
);

  localparam int unsigned ACC_W  = pira_pkg::ACC_W;
  localparam int unsigned RAW_W  = pira_pkg::RAW_W;
  localparam int unsigned EXC_W  = pira_pkg::EXCESS_W;
  localparam int unsigned SUM_W  = pira_pkg::SUM_W;

  logic                                    out_valid_r, out_valid_nxt;
  logic signed [pira_pkg::DATA_W-1:0]      drive_r;
  logic signed [pira_pkg::INTEG_W-1:0]     integ_r, integ_nxt;
  logic signed [EXC_W-1:0]                 excess_r, excess_nxt;

  logic signed [pira_pkg::BC_W-1:0]        backcalc;
  logic signed [ACC_W-1:0]                 acc, acc_c, ilo, ihi;
  logic signed [SUM_W-1:0]                 sum;
  logic signed [RAW_W-1:0]                 raw, drv_c, dlo, dhi;
  logic signed [RAW_W:0]                   diff;

  assign s1_take = s1_valid && (!out_valid_r || out_chan.ready);

  assign backcalc = excess_r * cfg.gain_backcalc;
  assign acc = ACC_W'(integ_r) + ACC_W'(s1_prod.integ_inc) - ACC_W'(backcalc);
  assign ilo = ACC_W'(cfg.integ_lower) <<< pira_pkg::FRAC_BITS;
  assign ihi = ACC_W'(cfg.integ_upper) <<< pira_pkg::FRAC_BITS;

  // lower test first, so inverted limits leave a value on one of the two
  always_comb begin
    if (acc < ilo) begin
      acc_c = ilo;
    end else if (acc > ihi) begin
      acc_c = ihi;
    end else begin
      acc_c = acc;
    end
  end

  assign integ_nxt = pira_pkg::INTEG_W'(acc_c);
  assign sum = SUM_W'(integ_nxt) + (SUM_W'(s1_prod.prop) <<< pira_pkg::PROP_SHIFT);
  // arithmetic shift right, rounds toward minus infinity
  assign raw = $signed(sum[SUM_W-1:pira_pkg::FRAC_BITS]);
  assign dlo = RAW_W'(cfg.drive_lower);
  assign dhi = RAW_W'(cfg.drive_upper);

  always_comb begin
    if (raw < dlo) begin
      drv_c = dlo;
    end else if (raw > dhi) begin
      drv_c = dhi;
    end else begin
      drv_c = raw;
    end
  end

  assign diff       = (RAW_W + 1)'(raw) - (RAW_W + 1)'(drv_c);
  assign excess_nxt = EXC_W'(diff);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      excess_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        integ_r  <= integ_nxt;
        excess_r <= excess_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      drive_r <= pira_pkg::DATA_W'(drv_c);
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.drive = drive_r;

  // integrator lands inside the limits in force at the update, or on one of
  // them when they are inverted
  a_integ_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=>
      ($past(cfg.integ_lower) > $past(cfg.integ_upper))
        ? ((ACC_W'(integ_r) == (ACC_W'($past(cfg.integ_lower)) <<< pira_pkg::FRAC_BITS)) ||
           (ACC_W'(integ_r) == (ACC_W'($past(cfg.integ_upper)) <<< pira_pkg::FRAC_BITS)))
        : ((ACC_W'(integ_r) >= (ACC_W'($past(cfg.integ_lower)) <<< pira_pkg::FRAC_BITS)) &&
           (ACC_W'(integ_r) <= (ACC_W'($past(cfg.integ_upper)) <<< pira_pkg::FRAC_BITS))))
    else $error("integrator outside its limits after update");

  // a nonzero excess only comes with a clamped drive
  a_excess_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=> (excess_r == '0) || (drive_r == $past(cfg.drive_lower)) ||
                (drive_r == $past(cfg.drive_upper)))
    else $error("excess kept while drive was not clamped");

  // drive stays within ordered output limits
  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && (cfg.drive_lower <= cfg.drive_upper)) |=>
      (drive_r >= $past(cfg.drive_lower)) && (drive_r <= $past(cfg.drive_upper)))
    else $error("drive outside output limits");

  // state only moves when an item moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_take |=> $stable(integ_r) && $stable(excess_r))
    else $error("regulator state changed without an item");

endmodule
